### rtl/id3ftr_pkg.sv
`timescale 1ns / 1ps

package id3ftr_pkg;

	localparam int HDR_LEN     = 10;
	localparam int QUEUE_DEPTH = 16;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W   = 3;

	typedef enum logic [1:0] {
		PH_FILE_HDR,
		PH_FRAME_HDR,
		PH_PAYLOAD,
		PH_PASS
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_TAG  = 3'd0,
		REG_TEXT_LENGTH = 3'd1,
		REG_TEXT_WORD_0 = 3'd2,
		REG_TEXT_WORD_1 = 3'd3,
		REG_TEXT_WORD_2 = 3'd4,
		REG_TEXT_WORD_3 = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] target_tag;
		logic [5:0]  text_length;
	} cfg_t;

	// one queue entry: a single byte in bytes[0], or a whole frame header
	typedef struct packed {
		logic                     hdr;
		logic [HDR_LEN-1:0][7:0]  bytes;
	} entry_t;

	typedef struct packed {
		logic not_full;
		logic not_empty;
	} q_status_t;

endpackage

### rtl/id3ftr_parser.sv
`timescale 1ns / 1ps

module id3ftr_parser import id3ftr_pkg::*; #(
	parameter int MAX_TEXT_BYTES = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [7:0]                     data_byte,
	input  logic                           file_start,
	input  cfg_t                           cfg,
	input  logic [MAX_TEXT_BYTES-1:0][7:0] text,
	output logic                           push,
	output entry_t                         entry
);

	localparam int TIW = (MAX_TEXT_BYTES > 1) ? $clog2(MAX_TEXT_BYTES) : 1;
	localparam logic [5:0] MaxLen = 6'(MAX_TEXT_BYTES);
	localparam logic [3:0] LastHdr = 4'(HDR_LEN - 1);

	phase_t      phase_q, phase_d, phase_e;
	logic [3:0]  cnt_q, cnt_d, cnt_e;
	logic [31:0] size_q, size_d, size_e;
	logic [31:0] off_q, off_d, off_e;
	logic        match_q, match_d, match_e;
	logic [7:0]  hs_q [HDR_LEN-1];
	logic        hs_we;

	logic [31:0] hdr_size;
	logic [31:0] off_inc;
	logic [31:0] off_m1;
	logic [5:0]  len_sat;
	logic        in_text;
	logic [7:0]  pay_byte;
	logic        tag_hit;

	always_comb begin
		logic done;
		logic [7:0] want;
		tag_hit = 1'b1;
		done    = 1'b0;
		for (int k = 0; k < 4; k++) begin
			want = cfg.target_tag[31-8*k -: 8];
			if (!done) begin
				if (hs_q[k] != want) begin
					tag_hit = 1'b0;
					done    = 1'b1;
				end else if (want == 8'h00) begin
					done = 1'b1;
				end
			end
		end
	end

	always_comb begin
		phase_e = file_start ? PH_FILE_HDR : phase_q;
		cnt_e   = file_start ? 4'd0 : cnt_q;
		size_e  = file_start ? 32'd0 : size_q;
		off_e   = file_start ? 32'd0 : off_q;
		match_e = file_start ? 1'b0 : match_q;
	end

	assign hdr_size = {hs_q[4], hs_q[5], hs_q[6], hs_q[7]};
	assign off_inc  = off_e + 32'd1;
	assign off_m1   = off_e - 32'd1;
	assign len_sat  = (cfg.text_length > MaxLen) ? MaxLen : cfg.text_length;
	assign in_text  = (off_e != 32'd0) && (off_m1 < {26'd0, len_sat});
	assign pay_byte = in_text ? text[off_m1[TIW-1:0]] : 8'h00;

	always_comb begin
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		size_d      = size_q;
		off_d       = off_q;
		match_d     = match_q;
		push        = 1'b0;
		hs_we       = 1'b0;
		entry.hdr   = 1'b0;
		entry.bytes = '0;
		entry.bytes[0] = data_byte;
		if (accept) begin
			phase_d = phase_e;
			cnt_d   = cnt_e;
			size_d  = size_e;
			off_d   = off_e;
			match_d = match_e;
			unique case (phase_e)
				PH_FILE_HDR: begin
					push = 1'b1;
					if (cnt_e == LastHdr) begin
						phase_d = PH_FRAME_HDR;
						cnt_d   = 4'd0;
					end else begin
						cnt_d = cnt_e + 4'd1;
					end
				end
				PH_FRAME_HDR: begin
					if (cnt_e == LastHdr) begin
						cnt_d  = 4'd0;
						size_d = hdr_size;
						if (hdr_size == 32'd0 || hs_q[0] == 8'h00) begin
							phase_d = PH_PASS;
						end else begin
							push      = 1'b1;
							entry.hdr = 1'b1;
							for (int k = 0; k < HDR_LEN - 1; k++) begin
								entry.bytes[k] = hs_q[k];
							end
							entry.bytes[HDR_LEN-1] = data_byte;
							match_d = tag_hit;
							off_d   = 32'd0;
							phase_d = PH_PAYLOAD;
						end
					end else begin
						hs_we = 1'b1;
						cnt_d = cnt_e + 4'd1;
					end
				end
				PH_PAYLOAD: begin
					push = 1'b1;
					if (match_e) begin
						entry.bytes[0] = pay_byte;
					end
					if (off_inc >= size_e) begin
						phase_d = PH_FRAME_HDR;
						cnt_d   = 4'd0;
						off_d   = 32'd0;
						match_d = 1'b0;
					end else begin
						off_d = off_inc;
					end
				end
				PH_PASS: begin
					push = 1'b1;
				end
				default: begin
					push = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FILE_HDR;
			cnt_q   <= 4'd0;
			size_q  <= 32'd0;
			off_q   <= 32'd0;
			match_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			size_q  <= size_d;
			off_q   <= off_d;
			match_q <= match_d;
		end
	end

	always_ff @(posedge clk) begin
		if (hs_we) begin
			hs_q[cnt_e] <= data_byte;
		end
	end

endmodule

### rtl/id3ftr_queue.sv
`timescale 1ns / 1ps

module id3ftr_queue import id3ftr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  entry_t    push_entry,
	input  logic      pop,
	output entry_t    head,
	output q_status_t status
);

	localparam logic [QCNT_W-1:0] Full = QCNT_W'(QUEUE_DEPTH);

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign status.not_full  = (count_q != Full);
	assign status.not_empty = (count_q != '0);
	assign head             = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != Full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue read while empty");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q) + QCNT_W'($past(push)) - QCNT_W'($past(pop)))
		else $error("queue fill count out of step");

endmodule

### rtl/id3ftr_serialiser.sv
`timescale 1ns / 1ps

module id3ftr_serialiser import id3ftr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_status_t  status,
	input  entry_t     head,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast
);

	logic [HDR_LEN-1:0][7:0] bytes_q;
	logic [3:0]              rem_q;
	logic                    busy;
	logic                    take;

	assign busy     = (rem_q != 4'd0);
	assign take     = !busy || (m_tready && rem_q == 4'd1);
	assign pop      = take && status.not_empty;
	assign m_tvalid = busy;
	assign m_tdata  = bytes_q[0];
	assign m_tlast  = (rem_q == 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 4'd0;
		end else if (pop) begin
			rem_q <= head.hdr ? 4'(HDR_LEN) : 4'd1;
		end else if (busy && m_tready) begin
			rem_q <= rem_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bytes_q <= head.bytes;
		end else if (busy && m_tready) begin
			bytes_q <= {8'h00, bytes_q[HDR_LEN-1:1]};
		end
	end

endmodule

### rtl/id3_frame_text_rewriter_unit.sv
`timescale 1ns / 1ps

// channel   dir  beat fields (low bit first)        accepted when
// s_*       in   tdata: data_byte; tuser: file_start s_tvalid && s_tready
// m_*       out  tdata: out_byte; tlast: run_last     m_tvalid && m_tready
// cfg_*     in   index, data                          cfg_wr_en
//
// one input beat per cycle while s_tready is high; a beat is parsed in the cycle it is taken
// a completed frame header leaves as a burst of ten output beats, one a cycle while m_tready is high
// results wait in a 16-entry queue; s_tready drops only when it is full
// an input beat reaches the output through the queue and then the serialiser register
// reset clears parse state, queue and configuration registers

module id3_frame_text_rewriter_unit import id3ftr_pkg::*; #(
	parameter int MAX_TEXT_BYTES = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // data_byte
	input  logic                 s_tuser,   // file_start
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // out_byte
	output logic                 m_tlast,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	cfg_t                           cfg_q;
	logic [MAX_TEXT_BYTES-1:0][7:0] text_q;
	logic                           accept;
	logic                           push;
	logic                           pop;
	entry_t                         entry;
	entry_t                         head;
	q_status_t                      status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TARGET_TAG:  cfg_q.target_tag  <= cfg_data[31:0];
				REG_TEXT_LENGTH: cfg_q.text_length <= cfg_data[5:0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	for (genvar n = 0; n < MAX_TEXT_BYTES; n++) begin : g_text
		localparam logic [CFG_IDX_W-1:0] WordIdx =
			CFG_IDX_W'(int'(REG_TEXT_WORD_0) + n / 8);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				text_q[n] <= 8'h00;
			end else if (cfg_wr_en && cfg_index == WordIdx) begin
				text_q[n] <= cfg_data[(n % 8) * 8 +: 8];
			end
		end
	end

	assign s_tready = status.not_full;
	assign accept   = s_tvalid && s_tready;

	id3ftr_parser #(
		.MAX_TEXT_BYTES(MAX_TEXT_BYTES)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (s_tdata),
		.file_start (s_tuser),
		.cfg        (cfg_q),
		.text       (text_q),
		.push       (push),
		.entry      (entry)
	);

	id3ftr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.pop        (pop),
		.head       (head),
		.status     (status)
	);

	id3ftr_serialiser u_serialiser (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
